// ===== rtl/calendar_date_stepper_top_assert.svh =====
// assertion macros for the calendar date stepper
`ifndef CALENDAR_DATE_STEPPER_TOP_ASSERT_SVH
`define CALENDAR_DATE_STEPPER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property on an explicit clock and active-low reset
`define CDS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property on the block clock and reset
`define CDS_ASSERT(lbl, prop, msg) \
  `CDS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CDS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define CDS_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/cds_pkg.sv =====
// types, constants and calendar helpers for the calendar date stepper
package cds_pkg;

  localparam int unsigned StepW  = 8;
  localparam int unsigned QDepth = 2;

  localparam logic [11:0] YearLow      = 12'd1900;
  localparam logic [11:0] YearHigh     = 12'd2100;
  localparam logic [3:0]  MonthFirst   = 4'd1;
  localparam logic [3:0]  MonthLast    = 4'd12;
  localparam logic [3:0]  MonthFeb     = 4'd2;
  localparam logic [4:0]  DayFirst     = 5'd1;
  localparam logic [4:0]  DayLeapFeb   = 5'd29;
  localparam logic [4:0]  DayLastOfDec = 5'd31;

  // month lengths, unused codes read as zero
  localparam logic [4:0] MonthLen [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_FWD  = 2'd1,
    OP_BACK = 2'd2,
    OP_CMP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_YEAR  = 3'd2,
    ST_BAD_DAY   = 3'd3,
    ST_RANGE     = 3'd4
  } st_e;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } ord_e;

  typedef struct packed {
    op_e              operation;
    logic [4:0]       in_day;
    logic [3:0]       in_month;
    logic [11:0]      in_year;
    logic [StepW-1:0] step_count;
  } in_t;

  typedef struct packed {
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [11:0] cur_year;
    st_e         status;
    ord_e        order;
  } out_t;

  // classified command handed from front end to back end
  typedef struct packed {
    op_e              kind;
    st_e              set_status;
    logic [StepW-1:0] count;
    logic [4:0]       day;
    logic [3:0]       month;
    logic [11:0]      year;
  } cmd_t;

  // leap rule for years 1900..2100: every fourth year except 1900 and 2100
  function automatic logic is_leap(logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != YearLow) && (y != YearHigh);
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] m, logic [11:0] y);
    logic [4:0] len;
    len = MonthLen[m];
    if ((m == MonthFeb) && is_leap(y)) begin
      len = DayLeapFeb;
    end
    return len;
  endfunction

endpackage

// ===== rtl/cds_front.sv =====
// front end: takes input beats, validates set requests and clamps step counts
module cds_front #(
  parameter int unsigned MAX_STEP = 255
) (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cds_pkg::in_t  in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output cds_pkg::cmd_t cmd_o
);
  import cds_pkg::*;

  localparam int unsigned StepMax = (1 << StepW) - 1;
  localparam logic [StepW-1:0] SatStep =
    StepW'((MAX_STEP > StepMax) ? StepMax : MAX_STEP);

  logic       month_ok;
  logic       year_ok;
  logic       day_ok;
  logic [4:0] dim;

  assign month_ok = (in_data_i.in_month >= MonthFirst) && (in_data_i.in_month <= MonthLast);
  assign year_ok  = (in_data_i.in_year >= YearLow) && (in_data_i.in_year <= YearHigh);
  assign dim      = days_in(in_data_i.in_month, in_data_i.in_year);
  assign day_ok   = (in_data_i.in_day >= DayFirst) && (in_data_i.in_day <= dim);

  always_comb begin
    cmd_o.kind  = in_data_i.operation;
    cmd_o.day   = in_data_i.in_day;
    cmd_o.month = in_data_i.in_month;
    cmd_o.year  = in_data_i.in_year;
    cmd_o.count = (in_data_i.step_count > SatStep) ? SatStep : in_data_i.step_count;
    priority if (!month_ok) begin
      cmd_o.set_status = ST_BAD_MONTH;
    end else if (!year_ok) begin
      cmd_o.set_status = ST_BAD_YEAR;
    end else if (!day_ok) begin
      cmd_o.set_status = ST_BAD_DAY;
    end else begin
      cmd_o.set_status = ST_OK;
    end
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

// ===== rtl/cds_queue.sv =====
// short command queue between front end and back end
module cds_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cds_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cds_pkg::cmd_t pop_data_o
);
  import cds_pkg::*;

  localparam int unsigned Aw = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam logic [Aw-1:0] LastPtr = Aw'(QDepth - 1);
  localparam logic [Aw:0]   FullCnt = (Aw + 1)'(QDepth);

  cmd_t          mem_q [QDepth];
  logic [Aw-1:0] wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0] rd_ptr_q, rd_ptr_d;
  logic [Aw:0]   cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/cds_back.sv =====
// back end: holds the date, walks it one day per cycle (last day waits for the result slot), compares, drives results
module cds_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cds_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cds_pkg::out_t out_data_o
);
  import cds_pkg::*;

  localparam logic SIdle = 1'b0;
  localparam logic SRun  = 1'b1;

  logic             state_q, state_d;
  logic             fwd_q, fwd_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [4:0]       day_q, day_d;
  logic [3:0]       month_q, month_d;
  logic [11:0]      year_q, year_d;
  out_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic        slot_free;
  logic        load;
  logic        is_walk;
  logic        step_ok;
  logic        finishing;
  logic [4:0]  nday;
  logic [3:0]  nmonth;
  logic [11:0] nyear;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_prev;
  ord_e        cmp_ord;

  assign slot_free = !res_valid_q || out_ready_i;
  assign is_walk   = ((cmd_i.kind == OP_FWD) || (cmd_i.kind == OP_BACK)) && (cmd_i.count != '0);
  assign cmd_ready_o = (state_q == SIdle) && (is_walk || slot_free);

  // one-day step unit
  assign dim_cur  = days_in(month_q, year_q);
  assign dim_prev = days_in(month_q - 4'd1, year_q);

  always_comb begin
    step_ok = 1'b1;
    nday    = day_q;
    nmonth  = month_q;
    nyear   = year_q;
    if (fwd_q) begin
      priority if (day_q < dim_cur) begin
        nday = day_q + 5'd1;
      end else if (month_q < MonthLast) begin
        nday   = DayFirst;
        nmonth = month_q + 4'd1;
      end else if (year_q >= YearHigh) begin
        step_ok = 1'b0;
      end else begin
        nday   = DayFirst;
        nmonth = MonthFirst;
        nyear  = year_q + 12'd1;
      end
    end else begin
      priority if (day_q > DayFirst) begin
        nday = day_q - 5'd1;
      end else if (month_q > MonthFirst) begin
        nmonth = month_q - 4'd1;
        nday   = dim_prev;
      end else if (year_q <= YearLow) begin
        step_ok = 1'b0;
      end else begin
        nyear  = year_q - 12'd1;
        nmonth = MonthLast;
        nday   = DayLastOfDec;
      end
    end
  end

  // stored date versus given date
  always_comb begin
    priority if (year_q != cmd_i.year) begin
      cmp_ord = (year_q < cmd_i.year) ? ORD_LESS : ORD_GREATER;
    end else if (month_q != cmd_i.month) begin
      cmp_ord = (month_q < cmd_i.month) ? ORD_LESS : ORD_GREATER;
    end else if (day_q != cmd_i.day) begin
      cmp_ord = (day_q < cmd_i.day) ? ORD_LESS : ORD_GREATER;
    end else begin
      cmp_ord = ORD_EQUAL;
    end
  end

  assign finishing = !step_ok || (cnt_q == StepW'(1));

  always_comb begin
    state_d = state_q;
    fwd_d   = fwd_q;
    cnt_d   = cnt_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    res_d   = res_q;
    load    = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (cmd_valid_i && cmd_ready_o) begin
          if (is_walk) begin
            state_d = SRun;
            fwd_d   = (cmd_i.kind == OP_FWD);
            cnt_d   = cmd_i.count;
          end else begin
            load            = 1'b1;
            res_d.cur_day   = day_q;
            res_d.cur_month = month_q;
            res_d.cur_year  = year_q;
            res_d.status    = ST_OK;
            res_d.order     = ORD_LESS;
            unique case (cmd_i.kind)
              OP_SET: begin
                res_d.status = cmd_i.set_status;
                if (cmd_i.set_status == ST_OK) begin
                  day_d           = cmd_i.day;
                  month_d         = cmd_i.month;
                  year_d          = cmd_i.year;
                  res_d.cur_day   = cmd_i.day;
                  res_d.cur_month = cmd_i.month;
                  res_d.cur_year  = cmd_i.year;
                end
              end
              OP_CMP: begin
                res_d.order = cmp_ord;
              end
              OP_FWD, OP_BACK: begin
                // zero count: date unchanged
              end
              default: begin
              end
            endcase
          end
        end
      end
      SRun: begin
        if (!finishing || slot_free) begin
          if (step_ok) begin
            day_d   = nday;
            month_d = nmonth;
            year_d  = nyear;
            cnt_d   = cnt_q - StepW'(1);
          end
          if (finishing) begin
            load            = 1'b1;
            state_d         = SIdle;
            res_d.cur_day   = nday;
            res_d.cur_month = nmonth;
            res_d.cur_year  = nyear;
            res_d.status    = step_ok ? ST_OK : ST_RANGE;
            res_d.order     = ORD_LESS;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    res_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      fwd_q       <= 1'b0;
      cnt_q       <= '0;
      day_q       <= DayFirst;
      month_q     <= MonthFirst;
      year_q      <= YearLow;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fwd_q       <= fwd_d;
      cnt_q       <= cnt_d;
      day_q       <= day_d;
      month_q     <= month_d;
      year_q      <= year_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

// ===== rtl/calendar_date_stepper_top.sv =====
// top level of the calendar date stepper
// Gregorian date keeper for 1 January 1900 .. 31 December 2100, reset to 1 January 1900.
// Every input beat yields exactly one result beat with the stored date after the
// operation, a status and a compare outcome. Set and compare flow at one beat per
// cycle while the result register is free. A step of n days (n clamped to MAX_STEP,
// at most 255) occupies the back end until the walk is done, because the single day
// incrementer/decrementer moves the date by one day per cycle, save that the last
// day waits for the result register to free up. A step that hits a range limit ends
// early with status 4 and keeps the days already walked. A two-entry queue lets the
// front end keep taking beats while the back end walks, and the result register lets
// the back end walk the next beat while the previous result still waits.
`include "calendar_date_stepper_top_assert.svh"

module calendar_date_stepper_top #(
  parameter int unsigned MAX_STEP = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cds_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cds_pkg::out_t out_data_o
);
  import cds_pkg::*;

  // classified commands, front end to queue
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // queue head, queue to back end
  logic head_valid;
  logic head_ready;
  cmd_t head;

  // result beat checks used by the assertions
  logic res_date_ok;
  logic res_range_ok;
  logic res_order_ok;

  // validation of set beats and step clamping
  cds_front #(
    .MAX_STEP (MAX_STEP)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // decouples acceptance from the day walk
  cds_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_data_o   (head)
  );

  // date registers, day walker, comparator, result register
  cds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_ready_o (head_ready),
    .cmd_i       (head),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // reported date lies in the supported calendar
  assign res_date_ok =
    (out_data_o.cur_year >= YearLow) && (out_data_o.cur_year <= YearHigh) &&
    (out_data_o.cur_month >= MonthFirst) && (out_data_o.cur_month <= MonthLast) &&
    (out_data_o.cur_day >= DayFirst) &&
    (out_data_o.cur_day <= days_in(out_data_o.cur_month, out_data_o.cur_year));

  // a range stop sits exactly on one of the two limits
  assign res_range_ok =
    (out_data_o.status != ST_RANGE) ||
    ((out_data_o.cur_year == YearHigh) && (out_data_o.cur_month == MonthLast) &&
     (out_data_o.cur_day == DayLastOfDec)) ||
    ((out_data_o.cur_year == YearLow) && (out_data_o.cur_month == MonthFirst) &&
     (out_data_o.cur_day == DayFirst));

  // only compare beats carry an order other than less, and compare never fails
  assign res_order_ok = (out_data_o.order == ORD_LESS) || (out_data_o.status == ST_OK);

  `CDS_ASSERT(a_date_in_range, out_valid_o |-> res_date_ok, "result date out of range")
  `CDS_ASSERT(a_range_at_limit, out_valid_o |-> res_range_ok, "range stop away from a limit")
  `CDS_ASSERT(a_order_with_ok, out_valid_o |-> res_order_ok, "order set on a failed beat")

endmodule

// ===== bench/tb_calendar_date_stepper_top.sv =====
// self-checking testbench for the calendar date stepper: directed and random beats
module tb_calendar_date_stepper_top;
  import cds_pkg::*;

  localparam int unsigned STEP_LIMIT = 255;
  // accepted beat count at which the receiver stops taking results for a while
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  // the beat at this index waits until every outstanding result is back
  localparam int DRAIN_AT = 700;
  localparam int RANDOM_TOTAL = 1150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  calendar_date_stepper_top #(
    .MAX_STEP(STEP_LIMIT)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // commands waiting to be driven, and results the block still owes us
  in_t date_cmds[$];
  out_t owed_dates[$];

  // our own copy of the stored date
  logic [4:0] cal_day;
  logic [3:0] cal_month;
  logic [11:0] cal_year;

  int n_sent;        // beats accepted on the input side (nonblocking, read by other blocks)
  int n_loaded;      // beats taken from date_cmds by the driver
  int send_gap;      // idle cycles left before the next input beat
  int n_got;         // result beats taken
  int recv_gap;      // idle cycles left before ready comes back
  int rx_hold;       // long receiver stall, counts down in its own block
  bit hold_done;
  int n_errors = 0;

  // full gregorian rule, not just every fourth year
  function automatic bit leap_year(logic [11:0] y);
    return ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
  endfunction

  function automatic int unsigned month_length(logic [3:0] m, logic [11:0] y);
    int unsigned len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      4'd2: len = leap_year(y) ? 29 : 28;
      default: len = 0;
    endcase
    return len;
  endfunction

  // move the stored date one day; 0 means the range limit blocked the move
  function automatic bit walk_one_day(bit fwd);
    if (fwd) begin
      if (cal_day < month_length(cal_month, cal_year)) begin
        cal_day = cal_day + 5'd1;
      end else if (cal_month < MonthLast) begin
        cal_day = DayFirst;
        cal_month = cal_month + 4'd1;
      end else if (cal_year >= YearHigh) begin
        return 1'b0;
      end else begin
        cal_day = DayFirst;
        cal_month = MonthFirst;
        cal_year = cal_year + 12'd1;
      end
    end else begin
      if (cal_day > DayFirst) begin
        cal_day = cal_day - 5'd1;
      end else if (cal_month > MonthFirst) begin
        cal_month = cal_month - 4'd1;
        cal_day = 5'(month_length(cal_month, cal_year));
      end else if (cal_year <= YearLow) begin
        return 1'b0;
      end else begin
        cal_year = cal_year - 12'd1;
        cal_month = MonthLast;
        cal_day = DayLastOfDec;
      end
    end
    return 1'b1;
  endfunction

  // apply one command to the stored date and return the result it must produce
  function automatic out_t advance_calendar(in_t c);
    out_t r;
    int unsigned days;
    r.status = ST_OK;
    r.order = ORD_LESS;
    case (c.operation)
      OP_SET: begin
        // checks go month, then year, then day; a failed set keeps the old date
        if (c.in_month < MonthFirst || c.in_month > MonthLast) begin
          r.status = ST_BAD_MONTH;
        end else if (c.in_year < YearLow || c.in_year > YearHigh) begin
          r.status = ST_BAD_YEAR;
        end else if (c.in_day < DayFirst ||
                     c.in_day > month_length(c.in_month, c.in_year)) begin
          r.status = ST_BAD_DAY;
        end else begin
          cal_day = c.in_day;
          cal_month = c.in_month;
          cal_year = c.in_year;
        end
      end
      OP_FWD, OP_BACK: begin
        days = c.step_count;
        if (days > STEP_LIMIT) begin
          days = STEP_LIMIT;
        end
        // days walked before hitting a limit are kept
        for (int unsigned i = 0; i < days && r.status == ST_OK; i++) begin
          if (!walk_one_day(c.operation == OP_FWD)) begin
            r.status = ST_RANGE;
          end
        end
      end
      default: begin
        // given fields are compared raw, even when not a real date
        if (cal_year != c.in_year) begin
          r.order = (cal_year < c.in_year) ? ORD_LESS : ORD_GREATER;
        end else if (cal_month != c.in_month) begin
          r.order = (cal_month < c.in_month) ? ORD_LESS : ORD_GREATER;
        end else if (cal_day != c.in_day) begin
          r.order = (cal_day < c.in_day) ? ORD_LESS : ORD_GREATER;
        end else begin
          r.order = ORD_EQUAL;
        end
      end
    endcase
    r.cur_day = cal_day;
    r.cur_month = cal_month;
    r.cur_year = cal_year;
    return r;
  endfunction

  // per-beat idle draw, with stretches where both sides run flat out
  function automatic int idle_cycles(int n);
    if (((n / 150) % 4) == 1) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic void push_cmd(op_e op, int d, int m, int y, int n);
    in_t c;
    c.operation = op;
    c.in_day = 5'(d);
    c.in_month = 4'(m);
    c.in_year = 12'(y);
    c.step_count = 8'(n);
    date_cmds.push_back(c);
  endfunction

  // years cluster at both ends of the range so the limits get hit
  function automatic int random_valid_year();
    case ($urandom_range(0, 3))
      0: return 1900 + $urandom_range(0, 2);
      1: return 2100 - $urandom_range(0, 2);
      default: return $urandom_range(1900, 2100);
    endcase
  endfunction

  // mostly short walks to keep run time down, now and then one of up to 255 days
  function automatic int step_len();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 255);
    end
    return $urandom_range(0, 40);
  endfunction

  // input side: one beat at a time from date_cmds, valid held until taken
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic offer;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      n_sent <= 0;
      n_loaded = 0;
      send_gap = 0;
      cal_day = DayFirst;
      cal_month = MonthFirst;
      cal_year = YearLow;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        // predict at acceptance, in beat order
        owed_dates.push_back(advance_calendar(in_data));
        n_sent <= n_sent + 1;
        offer = 1'b0;
        send_gap = idle_cycles(n_sent);
      end else if (!in_valid && send_gap > 0) begin
        send_gap--;
      end
      // one drain point: hold the next beat until the block has answered all
      if (!offer && send_gap == 0 && date_cmds.size() > 0 &&
          !(n_loaded == DRAIN_AT && owed_dates.size() != 0)) begin
        in_data <= date_cmds.pop_front();
        offer = 1'b1;
        n_loaded++;
      end
      in_valid <= offer;
    end
  end

  // long receiver stall once the input side is well under way
  always @(posedge clk_i or negedge rst_ni) begin : rx_hold_ctl
    if (!rst_ni) begin
      rx_hold <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      rx_hold <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end
  end

  // output side: check each result beat against the oldest owed date
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_gap = 0;
      n_got = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_dates.size() == 0) begin
          if (n_errors < 10) begin
            $display("unexpected result %0d-%0d-%0d status %0d order %0d",
                     out_data.cur_year, out_data.cur_month, out_data.cur_day,
                     out_data.status, out_data.order);
          end
          n_errors++;
        end else begin
          want = owed_dates.pop_front();
          if (out_data.cur_day !== want.cur_day || out_data.cur_month !== want.cur_month ||
              out_data.cur_year !== want.cur_year || out_data.status !== want.status ||
              out_data.order !== want.order) begin
            if (n_errors < 10) begin
              $display("result %0d: got %0d-%0d-%0d st %0d ord %0d, want %0d-%0d-%0d st %0d ord %0d",
                       n_got, out_data.cur_year, out_data.cur_month, out_data.cur_day,
                       out_data.status, out_data.order, want.cur_year, want.cur_month,
                       want.cur_day, want.status, want.order);
            end
            n_errors++;
          end
        end
        n_got++;
        recv_gap = idle_cycles(n_got + 75);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_ready <= (recv_gap == 0) && (rx_hold == 0);
    end
  end

  initial begin : stimulus
    int pick;
    int reps;
    int d;
    int m;
    int y;
    int cd;
    int cm;
    int cy;

    // directed: reset date, bad fields in check order, leap days, limits
    push_cmd(OP_CMP, 1, 1, 1900, 0);        // reset date compares equal
    push_cmd(OP_BACK, 0, 0, 0, 1);          // already at the lower limit
    push_cmd(OP_SET, 1, 0, 2000, 0);        // month zero
    push_cmd(OP_SET, 1, 13, 4095, 0);       // month wins over year
    push_cmd(OP_SET, 0, 15, 0, 0);          // top month code
    push_cmd(OP_SET, 10, 6, 1899, 0);       // year just below range
    push_cmd(OP_SET, 0, 6, 2101, 0);        // year wins over day
    push_cmd(OP_SET, 29, 2, 1900, 0);       // century, not leap
    push_cmd(OP_SET, 29, 2, 2100, 0);
    push_cmd(OP_SET, 31, 4, 2023, 0);       // 31 in a 30-day month
    push_cmd(OP_SET, 29, 2, 2000, 0);       // divisible by 400, leap
    push_cmd(OP_SET, 0, 2, 2024, 0);        // day zero
    push_cmd(OP_CMP, 29, 2, 2000, 0);
    push_cmd(OP_CMP, 1, 3, 2000, 0);
    push_cmd(OP_CMP, 31, 12, 1999, 0);
    push_cmd(OP_CMP, 31, 15, 4095, 0);      // raw compare of a bogus date
    push_cmd(OP_CMP, 31, 15, 0, 255);
    push_cmd(OP_FWD, 31, 15, 4095, 0);      // zero count is a no-op
    push_cmd(OP_FWD, 0, 0, 0, 1);           // leap day rolls into march
    push_cmd(OP_BACK, 0, 0, 0, 1);
    push_cmd(OP_SET, 20, 12, 2100, 0);
    push_cmd(OP_FWD, 0, 0, 0, 255);         // stops at the upper limit
    push_cmd(OP_SET, 5, 1, 1900, 0);
    push_cmd(OP_BACK, 0, 0, 0, 255);        // stops at the lower limit
    push_cmd(OP_SET, 28, 2, 1900, 0);
    push_cmd(OP_FWD, 0, 0, 0, 1);

    // random: mostly a valid set followed by walks and nearby compares
    while (date_cmds.size() < RANDOM_TOTAL) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        y = random_valid_year();
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_length(4'(m), 12'(y)));
        push_cmd(OP_SET, d, m, y, $urandom_range(0, 255));
        reps = $urandom_range(1, 4);
        for (int k = 0; k < reps; k++) begin
          case ($urandom_range(0, 4))
            0, 1: push_cmd(OP_FWD, $urandom_range(0, 31), $urandom_range(0, 15),
                           $urandom_range(0, 4095), step_len());
            2, 3: push_cmd(OP_BACK, $urandom_range(0, 31), $urandom_range(0, 15),
                           $urandom_range(0, 4095), step_len());
            default: begin
              // compare against the set date, one field nudged or none
              cd = d;
              cm = m;
              cy = y;
              case ($urandom_range(0, 3))
                1: cd = cd + $urandom_range(0, 2) - 1;
                2: cm = cm + $urandom_range(0, 2) - 1;
                3: cy = cy + $urandom_range(0, 2) - 1;
                default: ;
              endcase
              push_cmd(OP_CMP, cd, cm, cy, $urandom_range(0, 255));
            end
          endcase
        end
      end else if (pick == 7) begin
        // broken sets: fully random fields, a day just past the month end, or 29 February in a year that is not leap
        case ($urandom_range(0, 2))
          0: push_cmd(OP_SET, $urandom_range(0, 31), $urandom_range(0, 15),
                      $urandom_range(0, 4095), $urandom_range(0, 255));
          1: begin
            y = random_valid_year();
            m = $urandom_range(1, 12);
            push_cmd(OP_SET, month_length(4'(m), 12'(y)) + 1, m, y, 0);
          end
          default: begin
            y = (($urandom_range(0, 1) == 1) ? 1900 : 2100);
            if ($urandom_range(0, 1) == 1) begin
              y = 1901 + 4 * $urandom_range(0, 49) + $urandom_range(0, 2);
            end
            push_cmd(OP_SET, 29, 2, y, 0);
          end
        endcase
      end else if (pick == 8) begin
        push_cmd(($urandom_range(0, 1) == 1) ? OP_FWD : OP_BACK, $urandom_range(0, 31),
                 $urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 255));
      end else begin
        push_cmd(OP_CMP, $urandom_range(0, 31), $urandom_range(0, 15),
                 $urandom_range(0, 4095), $urandom_range(0, 255));
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all beats out, then all results back, then a short settle
    while (date_cmds.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    while (owed_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // timeout well beyond the worst-case run time
  initial begin : watchdog
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
